/* design/idasc_pkg.sv */
package idasc_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = 4;
  localparam int CHAR_W     = 6;

  // double dabble: one step per magnitude bit, split over the dabble stages
  localparam int DD_STAGES = 4;
  localparam int DD_STEPS  = VALUE_W / DD_STAGES;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
  localparam logic [DIGIT_W-1:0] DD_LIMIT   = 4'd5;
  localparam logic [DIGIT_W-1:0] DD_ADJUST  = 4'd3;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef struct packed {
    logic               neg;
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } work_t;

  // DD_STEPS shift-and-adjust steps of the binary to BCD conversion
  function automatic work_t dabble_steps(input work_t w_in);
    work_t w;
    w = w_in;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (w.bcd[d] >= DD_LIMIT) begin
          w.bcd[d] = w.bcd[d] + DD_ADJUST;
        end
      end
      {w.bcd, w.bin} = {w.bcd, w.bin} << 1;
    end
    return w;
  endfunction

endpackage

/* design/idasc_dabble_stage.sv */
module idasc_dabble_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  idasc_pkg::work_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output idasc_pkg::work_t dn_data
);

  logic             valid_r;
  idasc_pkg::work_t data_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= idasc_pkg::dabble_steps(up_data);
    end
  end

endmodule

/* design/idasc_serializer.sv */
module idasc_serializer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  idasc_pkg::work_t                 up_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [idasc_pkg::CHAR_W-1:0]     out_char,
  output logic                             out_last
);

  logic                          busy_r;
  logic                          sign_pend_r;
  logic                          sign_pend_nxt;
  logic [idasc_pkg::IDX_W-1:0]   idx_r;
  logic [idasc_pkg::IDX_W-1:0]   idx_nxt;
  idasc_pkg::bcd_t               bcd_r;
  logic                          out_valid_r;
  logic [idasc_pkg::CHAR_W-1:0]  out_char_r;
  logic                          out_last_r;

  logic                          emit;
  logic                          cur_last;
  logic                          load;
  logic [idasc_pkg::CHAR_W-1:0]  cur_char;
  logic [idasc_pkg::IDX_W-1:0]   top_idx;

  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign cur_last = !sign_pend_r && (idx_r == '0);
  assign up_ready = !busy_r || (emit && cur_last);
  assign load     = up_valid && up_ready;

  // most significant nonzero digit; zero keeps index 0 so one '0' goes out
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < idasc_pkg::NUM_DIGITS; d++) begin
      if (up_data.bcd[d] != '0) begin
        top_idx = idasc_pkg::IDX_W'(d);
      end
    end
  end

  always_comb begin
    if (sign_pend_r) begin
      cur_char      = idasc_pkg::CHAR_MINUS;
      sign_pend_nxt = 1'b0;
      idx_nxt       = idx_r;
    end else begin
      cur_char      = idasc_pkg::CHAR_ZERO + {2'b00, bcd_r[idx_r]};
      sign_pend_nxt = 1'b0;
      idx_nxt       = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && cur_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= cur_char;
      out_last_r <= cur_last;
    end
    if (load) begin
      bcd_r       <= up_data.bcd;
      sign_pend_r <= up_data.neg;
      idx_r       <= top_idx;
    end else if (emit) begin
      sign_pend_r <= sign_pend_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

/* design/int_to_decimal_ascii_core.sv */
// Signed 32-bit integer to decimal ASCII text. Each input transaction carries
// one two's complement value; the block answers with a run of 1 to 11 output
// transactions, one character each, most significant first: '-' for a
// negative value, then the digits with no leading zeros (zero gives "0").
// tlast marks the final character of each run. The value passes a sign and
// magnitude stage and four double-dabble stages of eight steps each, then the
// character serializer. The serializer sends one character per cycle while
// out_tready is high and takes the next number as it sends the last character
// of the current one; further values queue in the pipeline stages meanwhile.
module int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] character, [7:6] zero
  output logic        out_tlast   // last
);

  logic                    front_valid_r;
  idasc_pkg::work_t        front_data_r;
  idasc_pkg::work_t        front_nxt;
  logic                    front_ready;
  logic                    raw_neg;

  logic             st_valid [idasc_pkg::DD_STAGES+1];
  logic             st_ready [idasc_pkg::DD_STAGES+1];
  idasc_pkg::work_t st_data  [idasc_pkg::DD_STAGES+1];

  logic [idasc_pkg::CHAR_W-1:0] ser_char;

  // sign and magnitude; the magnitude is unsigned so the most negative value fits
  assign raw_neg = in_tdata[idasc_pkg::VALUE_W-1];
  always_comb begin
    front_nxt.neg = raw_neg;
    front_nxt.bcd = '0;
    front_nxt.bin = raw_neg ? (idasc_pkg::VALUE_W'(0) - in_tdata) : in_tdata;
  end

  assign front_ready = !front_valid_r || st_ready[0];
  assign in_tready   = front_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (front_ready) begin
      front_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready && in_tvalid) begin
      front_data_r <= front_nxt;
    end
  end

  assign st_valid[0] = front_valid_r;
  assign st_data[0]  = front_data_r;

  for (genvar g = 0; g < idasc_pkg::DD_STAGES; g++) begin : g_dabble
    idasc_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[g]),
      .up_ready (st_ready[g]),
      .up_data  (st_data[g]),
      .dn_valid (st_valid[g+1]),
      .dn_ready (st_ready[g+1]),
      .dn_data  (st_data[g+1])
    );
  end

  idasc_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (st_valid[idasc_pkg::DD_STAGES]),
    .up_ready  (st_ready[idasc_pkg::DD_STAGES]),
    .up_data   (st_data[idasc_pkg::DD_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (ser_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, ser_char};

endmodule

/* design/idasc_checker.sv */
module idasc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("stalled input transaction changed");

  // hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transaction changed");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == 8'd45) || (out_tdata >= 8'd48 && out_tdata <= 8'd57))
    else $error("output is not a minus sign or a digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 8'd45 |-> !out_tlast)
    else $error("minus sign ends a run");

  // a digit never follows a minus sign as a leading zero
  a_no_minus_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == 8'd45 |=>
      !out_tvalid || out_tdata != 8'd48)
    else $error("leading zero after minus sign");

endmodule

bind int_to_decimal_ascii_core idasc_checker u_idasc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
